/* rtl/lfu_cache_table_defines.svh */
// ----------------------------------------------------------------------------
// lfu cache table assertion macros
// assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define LCT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LCT_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LCT_ASSERT(label, clk, rst_n, prop)
`define LCT_ASSERT_NR(label, clk, prop)
`endif
`endif

/* rtl/lct_pkg.sv */
// ----------------------------------------------------------------------------
// lct_pkg
// shared types and codes for the lfu cache table
// ----------------------------------------------------------------------------
package lct_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_UPDATE,
        ST_OUT
    } state_t;

endpackage

/* rtl/lct_if.sv */
// ----------------------------------------------------------------------------
// lct channel interfaces
// valid/ready channels for requests, responses and capacity writes
// ----------------------------------------------------------------------------
interface lct_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
    modport source (output valid, command, lookup_key, store_value, input ready);
    modport sink   (input valid, command, lookup_key, store_value, output ready);
endinterface

interface lct_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic signed [31:0] read_value;
    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lct_cfg_if;
    logic        valid;
    logic        ready;
    logic [4:0]  data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/lct_ram.sv */
// ----------------------------------------------------------------------------
// lct_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module lct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH+1)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    a;

    assign a = addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[a] <= wdata;
        end
        rdata <= mem[a];
    end
endmodule

/* rtl/lfu_cache_table.sv */
// ----------------------------------------------------------------------------
// lfu_cache_table
// key/value cache, least frequently used replacement, lru tie break
// ----------------------------------------------------------------------------
// One request at a time. Entry words {key, value, count, rank} sit in one
// ram; valid bits in flops. A request walks the ram once to find the hit,
// the victim and the first free slot, then the EVICT state settles eviction
// and insertion, then a second walk reads and writes back each entry in turn
// to rewrite ranks, counts and the touched or inserted entry. The reads and
// write backs of the second walk share the single ram port.
module lfu_cache_table #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    lct_cfg_if.sink   cfg,
    lct_req_if.sink   req,
    lct_rsp_if.source rsp
);
    import lct_pkg::*;
    `include "lfu_cache_table_defines.svh"

    localparam int IW   = $clog2(ENTRIES + 1);
    localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WW   = KEY_W + VAL_W + COUNT_BITS + RW;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    state_t state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [IW-1:0] occ_reg;
    logic [IW-1:0] idx_reg;
    logic          rd_ok_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic          hit_reg;
    logic [IW-1:0] hidx_reg;
    logic [RW-1:0] hrank_reg;
    logic [VAL_W-1:0] hval_reg;
    logic          vfound_reg;
    logic [IW-1:0] vidx_reg;
    logic [COUNT_BITS-1:0] vcnt_reg;
    logic [RW-1:0] vrank_reg;
    logic          ffound_reg;
    logic [IW-1:0] fidx_reg;
    logic          evict_reg;
    logic          ins_reg;
    logic          rsp_hit_reg;
    logic [VAL_W-1:0] rsp_val_reg;

    logic          we;
    logic [IW-1:0] addr;
    logic [WW-1:0] wdata, rdata;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [RW-1:0] r_rank;
    logic          r_v;
    logic [IW-1:0] eff_cap;
    logic          start;
    logic          do_evict;
    logic          do_ins;
    logic [IW-1:0] ins_slot;

    lct_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_ram
    (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign {r_key, r_val, r_cnt, r_rank} = rdata;
    assign r_v = valid_reg[rd_idx_reg[RW-1:0]];
    assign eff_cap = (32'(cap_reg) > 32'(ENTRIES)) ? IW'(ENTRIES) : IW'(cap_reg);
    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign start = req.valid && req.ready;
    assign rsp.valid = (state_reg == ST_OUT);
    assign rsp.hit = rsp_hit_reg;
    assign rsp.read_value = rsp_val_reg;

    // eviction and insertion decided after the scan
    assign do_evict = cmd_reg == CMD_PUT && eff_cap != '0 && !hit_reg
        && occ_reg >= eff_cap && vfound_reg;
    assign do_ins = cmd_reg == CMD_PUT && eff_cap != '0 && !hit_reg
        && (ffound_reg || do_evict);
    assign ins_slot = (do_evict && !(ffound_reg && fidx_reg < vidx_reg)) ? vidx_reg
        : fidx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_SCAN;
            ST_SCAN:   if (rd_ok_reg && rd_idx_reg == LAST) state_next = ST_EVICT;
            ST_EVICT:  state_next = ST_UPDATE;
            ST_UPDATE: if (rd_ok_reg && rd_idx_reg == LAST) state_next = ST_OUT;
            ST_OUT:    if (rsp.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ram port: read walk, write back in the cycle after the read
    always_comb
    begin
        logic [RW-1:0] nr;
        logic [COUNT_BITS-1:0] nc;
        logic [VAL_W-1:0] nv;
        logic [KEY_W-1:0] nk;
        logic touched, inserted, live;
        nr = r_rank;
        nc = r_cnt;
        nv = r_val;
        nk = r_key;
        touched  = hit_reg && rd_idx_reg == hidx_reg && (cmd_reg == CMD_GET || eff_cap != '0);
        inserted = ins_reg && rd_idx_reg == fidx_reg;
        live = r_v && !(evict_reg && rd_idx_reg == vidx_reg);
        if (touched)
        begin
            nr = '0;
            if (r_cnt != CMAX) nc = r_cnt + 1'b1;
            if (cmd_reg == CMD_PUT) nv = val_reg;
        end
        else if (inserted)
        begin
            nr = '0;
            nc = COUNT_BITS'(1);
            nv = val_reg;
            nk = key_reg;
        end
        else if (live)
        begin
            if (evict_reg && r_rank > vrank_reg) nr = r_rank - 1'b1;
            if (hit_reg && r_rank < hrank_reg && (cmd_reg == CMD_GET || eff_cap != '0))
                nr = r_rank + 1'b1;
            if (ins_reg)
                nr = nr + 1'b1;
        end
        wdata = {nk, nv, nc, nr};
        we = (state_reg == ST_UPDATE) && rd_ok_reg;
        addr = we ? rd_idx_reg : idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_W'(16);
            valid_reg <= '0;
            occ_reg   <= '0;
            idx_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid) cap_reg <= cfg.data;
            rd_ok_reg <= 1'b0;
            if (start)
            begin
                idx_reg <= '0;
            end
            else if ((state_reg == ST_SCAN || (state_reg == ST_UPDATE && !rd_ok_reg))
                && idx_reg != IW'(ENTRIES))
            begin
                // in the update walk a write back cycle follows each read
                rd_ok_reg <= 1'b1;
                idx_reg <= idx_reg + 1'b1;
            end
            else if (state_reg == ST_EVICT)
            begin
                idx_reg <= '0;
                if (do_evict) valid_reg[vidx_reg[RW-1:0]] <= 1'b0;
                if (do_ins) valid_reg[ins_slot[RW-1:0]] <= 1'b1;
                occ_reg <= occ_reg - IW'(do_evict) + IW'(do_ins);
            end
        end
    end

    // scan datapath
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (start)
        begin
            cmd_reg    <= req.command;
            key_reg    <= req.lookup_key;
            val_reg    <= req.store_value;
            hit_reg    <= 1'b0;
            vfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
        end
        else if (state_reg == ST_SCAN && rd_ok_reg)
        begin
            if (r_v && r_key == key_reg && !hit_reg)
            begin
                hit_reg   <= 1'b1;
                hidx_reg  <= rd_idx_reg;
                hrank_reg <= r_rank;
                hval_reg  <= r_val;
            end
            if (r_v && (!vfound_reg || r_cnt < vcnt_reg
                || (r_cnt == vcnt_reg && r_rank > vrank_reg)))
            begin
                vfound_reg <= 1'b1;
                vidx_reg   <= rd_idx_reg;
                vcnt_reg   <= r_cnt;
                vrank_reg  <= r_rank;
            end
            if (!r_v && !ffound_reg)
            begin
                ffound_reg <= 1'b1;
                fidx_reg   <= rd_idx_reg;
            end
        end
        else if (state_reg == ST_EVICT)
        begin
            evict_reg   <= do_evict;
            ins_reg     <= do_ins;
            fidx_reg    <= ins_slot;
            rsp_hit_reg <= hit_reg;
            rsp_val_reg <= (hit_reg && cmd_reg == CMD_GET) ? hval_reg : '1;
        end
    end

    `LCT_ASSERT(a_rsp_not_idle, clk, rst_n, rsp.valid |-> !req.ready)
    `LCT_ASSERT(a_occ_bound, clk, rst_n, occ_reg <= IW'(ENTRIES))
    `LCT_ASSERT(a_occ_count, clk, rst_n, state_reg == ST_IDLE |-> $countones(valid_reg) == 32'(occ_reg))
endmodule
